// ===== sv/per_flow_token_bucket_policer_macros.svh =====
// Assertion helpers used by the policer datapath module.
// Each helper expects the enclosing module to have clk and rst_n.
`ifndef PER_FLOW_TOKEN_BUCKET_POLICER_MACROS_SVH
`define PER_FLOW_TOKEN_BUCKET_POLICER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PFTBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition must never be true outside reset.
`define PFTBP_NEVER(label, cond, msg) \
    `PFTBP_ASSERT(label, !(cond), msg)

`endif

// ===== sv/pftbp_pkg.sv =====
package pftbp_pkg;

    localparam int DEFAULT_FLOW_ENTRIES = 256;

    localparam int REG_W       = 40;
    localparam int TIME_W      = 64;
    localparam int ADDR_W      = 32;
    localparam int ETYPE_W     = 16;
    localparam int VERDICT_W   = 2;
    localparam int CFG_INDEX_W = 8;

    localparam longint unsigned TOKEN_COUNT   = 64'd5;
    localparam longint unsigned TOKEN_REGEN   = 64'd1;
    localparam longint unsigned NS_PER_SECOND = 64'd1000000000;

    localparam logic [REG_W-1:0] TOKEN_PERIOD_RESET =
        REG_W'(NS_PER_SECOND / TOKEN_REGEN);
    localparam logic [REG_W-1:0] BURST_SPAN_RESET =
        REG_W'((TOKEN_COUNT - 64'd1) * (NS_PER_SECOND / TOKEN_REGEN));

    localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4 = 16'h0800;

    localparam logic [CFG_INDEX_W-1:0] CFG_TOKEN_PERIOD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BURST_SPAN   = 8'd1;

    localparam logic [VERDICT_W-1:0] VERDICT_PASS    = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_FORWARD = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_DROP    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_JUDGE,
        ST_WRITE,
        ST_DONE
    } pftbp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan;
        logic take_window;
        logic judge;
        logic write;
        logic deliver;
    } pftbp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic policed;
        logic hit;
        logic miss;
        logic out_free;
    } pftbp_sts_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [TIME_W-1:0] low;
        logic [TIME_W-1:0] high;
    } pftbp_entry_t;

endpackage

// ===== sv/pftbp_ram.sv =====
module pftbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/pftbp_ctrl.sv =====
module pftbp_ctrl
    import pftbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  pftbp_sts_t sts,
    output pftbp_cmd_t cmd
);

    pftbp_state_t state_reg;
    pftbp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.policed ? ST_LOOKUP : ST_DONE;
                end
            end
            ST_LOOKUP:
            begin
                if (sts.hit || sts.miss)
                begin
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_LOOKUP:
            begin
                cmd.scan        = 1'b1;
                cmd.take_window = sts.hit || sts.miss;
            end
            ST_JUDGE:
            begin
                cmd.judge = 1'b1;
            end
            ST_WRITE:
            begin
                cmd.write = 1'b1;
            end
            ST_DONE:
            begin
                cmd.deliver = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/pftbp_dp.sv =====
`include "per_flow_token_bucket_policer_macros.svh"

module pftbp_dp
    import pftbp_pkg::*;
#(
    parameter int FLOW_ENTRIES = DEFAULT_FLOW_ENTRIES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]       cfg_data,
    input  logic [ETYPE_W-1:0]     eth_type,
    input  logic                   headers_present,
    input  logic [ADDR_W-1:0]      src_ip,
    input  logic [TIME_W-1:0]      time_ns,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [VERDICT_W-1:0]   verdict,
    input  pftbp_cmd_t             cmd,
    output pftbp_sts_t             sts
);

    localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
    localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(FLOW_ENTRIES);

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[TIME_W] ? '1 : s[TIME_W-1:0];
        end
    endfunction

    function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        return (a >= b) ? a - b : '0;
    endfunction

    // Configuration
    logic [REG_W-1:0] period_reg;
    logic [REG_W-1:0] burst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= TOKEN_PERIOD_RESET;
            burst_reg  <= BURST_SPAN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TOKEN_PERIOD: period_reg <= cfg_data;
                CFG_BURST_SPAN:   burst_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    logic [TIME_W-1:0] period_ext;
    logic [TIME_W-1:0] burst_ext;

    assign period_ext = {{(TIME_W-REG_W){1'b0}}, period_reg};
    assign burst_ext  = {{(TIME_W-REG_W){1'b0}}, burst_reg};

    // Packet registers
    logic              policed_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] fresh_lo_reg;
    logic [TIME_W-1:0] fresh_hi_reg;
    logic              policed;

    assign policed = headers_present && (eth_type == ETHERTYPE_IPV4);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            policed_reg  <= policed;
            addr_reg     <= src_ip;
            now_reg      <= time_ns;
            fresh_lo_reg <= sat_sub(time_ns, burst_ext);
            fresh_hi_reg <= sat_add(time_ns, period_ext);
        end
    end

    // Flow table scan
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_pend_reg;
    logic               issue;
    pftbp_entry_t       rd_entry;
    logic               ram_we;
    pftbp_entry_t       wr_entry;

    assign issue = cmd.scan && (scan_idx_reg < count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            rd_pend_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            rd_pend_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            scan_idx_reg <= '0;
        end
        else if (issue)
        begin
            scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            rd_idx_reg   <= scan_idx_reg[IDX_W-1:0];
        end
    end

    assign sts.policed  = policed;
    assign sts.hit      = rd_pend_reg && (rd_entry.address == addr_reg);
    assign sts.miss     = !rd_pend_reg && !issue;

    // Window load and judgment
    logic              hit_reg;
    logic              free_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [TIME_W-1:0] lo_reg;
    logic [TIME_W-1:0] hi_reg;
    logic              lt_reg;
    logic              gt_reg;
    logic [TIME_W-1:0] slide_lo_reg;
    logic [TIME_W-1:0] slide_hi_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take_window)
        begin
            hit_reg <= sts.hit;
            if (sts.hit)
            begin
                lo_reg   <= rd_entry.low;
                hi_reg   <= rd_entry.high;
                idx_reg  <= rd_idx_reg;
                free_reg <= 1'b0;
            end
            else
            begin
                lo_reg   <= fresh_lo_reg;
                hi_reg   <= fresh_hi_reg;
                idx_reg  <= count_reg[IDX_W-1:0];
                free_reg <= (count_reg < ENTRIES_CNT);
            end
        end
        if (cmd.judge)
        begin
            lt_reg       <= (now_reg < lo_reg);
            gt_reg       <= (now_reg > hi_reg);
            slide_lo_reg <= sat_add(lo_reg, period_ext);
            slide_hi_reg <= sat_add(hi_reg, period_ext);
        end
    end

    // Write back; a dropped packet leaves its entry alone
    assign ram_we           = cmd.write && !lt_reg && (hit_reg || free_reg);
    assign wr_entry.address = addr_reg;
    assign wr_entry.low     = gt_reg ? fresh_lo_reg : slide_lo_reg;
    assign wr_entry.high    = gt_reg ? fresh_hi_reg : slide_hi_reg;

    always_comb
    begin
        count_next = count_reg;
        if (ram_we && !hit_reg)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    pftbp_ram #(
        .WIDTH ($bits(pftbp_entry_t)),
        .DEPTH (FLOW_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (wr_entry),
        .re    (issue),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    // Output register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [VERDICT_W-1:0] verdict_reg;

    assign sts.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.deliver)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.deliver)
        begin
            if (!policed_reg)
            begin
                verdict_reg <= VERDICT_PASS;
            end
            else
            begin
                verdict_reg <= lt_reg ? VERDICT_DROP : VERDICT_FORWARD;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    `PFTBP_NEVER(a_count_bound, count_reg > ENTRIES_CNT, "flow count beyond table size")
    `PFTBP_ASSERT(a_count_step, !$stable(count_reg) |-> $past(ram_we), "count moved with no write")
    `PFTBP_NEVER(a_write_on_drop, ram_we && lt_reg, "table written for a dropped packet")
    `PFTBP_NEVER(a_deliver_blocked, cmd.deliver && !sts.out_free, "result over a stalled one")

endmodule

// ===== sv/per_flow_token_bucket_policer.sv =====
// Per-flow two-color token bucket policer. Each packet gets one verdict: pass (not
// complete IPv4), forward, or drop. IPv4 flows are keyed by source address in a
// table of FLOW_ENTRIES entries kept in a single-port-read RAM and filled in order;
// lookup walks the stored entries one per cycle, so a new flow walks all of them, and a
// non-IPv4 or truncated packet skips the lookup; a packet also waits while the previous
// verdict stays stalled in the output register. A full table judges new flows as fresh
// without storing them. The next packet is taken while a finished verdict is still held
// in the output register. Configuration writes (index 0: token period, index 1: burst
// span, both 40 bits) are always ready and must be issued only while the block is idle.
module per_flow_token_bucket_policer
    import pftbp_pkg::*;
#(
    parameter int FLOW_ENTRIES = DEFAULT_FLOW_ENTRIES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ETYPE_W-1:0]     eth_type,
    input  logic                   headers_present,
    input  logic [ADDR_W-1:0]      src_ip,
    input  logic [TIME_W-1:0]      time_ns,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [VERDICT_W-1:0]   verdict
);

    pftbp_cmd_t cmd;
    pftbp_sts_t sts;

    assign cfg_ready = 1'b1;

    pftbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    pftbp_dp #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .eth_type        (eth_type),
        .headers_present (headers_present),
        .src_ip          (src_ip),
        .time_ns         (time_ns),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .verdict         (verdict),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule
